>>> rtl/slcan_pkg.sv
// shared types and constants for the serial-line can ascii frame decoder
// no dependencies; imported by every module of the block
`default_nettype none

package slcan_pkg;

  // line length limit in stored characters
  localparam int unsigned MaxLineDefault = 33;

  // depth of the queue between classifier and parser
  localparam int unsigned QueueDepth = 2;

  // widths fixed by the frame format
  localparam int unsigned IdWidth      = 29;
  localparam int unsigned DlcWidth     = 4;
  localparam int unsigned PayloadWidth = 64;
  localparam int unsigned NibbleCount  = PayloadWidth / 4;

  // characters with a meaning of their own
  localparam logic [7:0] ChCr  = 8'h0d;
  localparam logic [7:0] ChBel = 8'h07;

  // command letters that open a line
  localparam logic [7:0] ChStdData   = 8'h74;  // t
  localparam logic [7:0] ChStdRemote = 8'h72;  // r
  localparam logic [7:0] ChExtData   = 8'h54;  // T
  localparam logic [7:0] ChExtRemote = 8'h52;  // R

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ABORTED  = 2'd1,
    STATUS_BAD      = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_ERR  = 2'd0,
    KIND_TERM = 2'd1,
    KIND_CHAR = 2'd2
  } kind_e;

  // one classified item as it travels from the front to the parser
  typedef struct packed {
    kind_e      kind;
    logic [3:0] nib;      // hex value, or dlc value for a digit
    logic       hex_ok;
    logic       cmd_ok;
    logic       cmd_ext;
    logic       cmd_rtr;
    logic       dlc_ok;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/slcan_front.sv
// front part: holds the carrier mode register and classifies each received item
// depends on slcan_pkg
`default_nettype none

module slcan_front import slcan_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_data_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       line_error_i,
  input  wire logic       carrier_on_i,
  output item_t           item_o
);

  logic ignore_carrier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_carrier_q <= 1'b0;
    end else if (cfg_we_i) begin
      ignore_carrier_q <= cfg_data_i;
    end
  end

  always_comb begin
    item_o = '0;

    if (line_error_i || (!carrier_on_i && !ignore_carrier_q)) begin
      item_o.kind = KIND_ERR;
    end else if (rx_byte_i == ChCr || rx_byte_i == ChBel) begin
      item_o.kind = KIND_TERM;
    end else begin
      item_o.kind = KIND_CHAR;
    end

    // hex digit in either case
    if (rx_byte_i inside {[8'h30:8'h39]}) begin
      item_o.nib    = rx_byte_i[3:0];
      item_o.hex_ok = 1'b1;
    end else if (rx_byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      item_o.nib    = rx_byte_i[3:0] + 4'd9;
      item_o.hex_ok = 1'b1;
    end

    // dlc digit zero to eight
    item_o.dlc_ok = rx_byte_i inside {[8'h30:8'h38]};

    // command letters t r T R
    item_o.cmd_ok  = rx_byte_i inside {ChStdData, ChStdRemote, ChExtData, ChExtRemote};
    item_o.cmd_ext = rx_byte_i == ChExtData || rx_byte_i == ChExtRemote;
    item_o.cmd_rtr = rx_byte_i == ChStdRemote || rx_byte_i == ChExtRemote;
  end

endmodule

`default_nettype wire

>>> rtl/slcan_fifo.sv
// short register queue of classified items between front and parser
// depends on slcan_pkg
`default_nettype none

module slcan_fifo import slcan_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  item_t     item_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output item_t     item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slcan_back.sv
// back part: line parser state, frame checks and the output register
// depends on slcan_pkg
`default_nettype none

module slcan_back import slcan_pkg::*; #(
  parameter int unsigned MAX_LINE = MaxLineDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    item_valid_i,
  input  item_t                        item_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [1:0]                   status_o,
  output logic [IdWidth-1:0]           frame_id_o,
  output logic                         extended_o,
  output logic                         remote_o,
  output logic [DlcWidth-1:0]          length_code_o,
  output logic [PayloadWidth-1:0]      payload_o
);

  localparam int unsigned CW = $clog2(MAX_LINE + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_LINE);

  logic [CW-1:0]           count_q, count_d;
  logic                    error_seen_q, error_seen_d;
  logic                    line_bad_q, line_bad_d;
  logic                    ext_q, ext_d;
  logic                    rtr_q, rtr_d;
  logic [IdWidth-1:0]      id_q, id_d;
  logic [DlcWidth-1:0]     dlc_q, dlc_d;
  logic [PayloadWidth-1:0] data_q, data_d;

  logic                    adv;
  logic                    res_valid;
  status_e                 res_status;
  logic [IdWidth-1:0]      res_id;
  logic                    res_ext;
  logic                    res_rtr;
  logic [DlcWidth-1:0]     res_dlc;
  logic [PayloadWidth-1:0] res_data;
  logic [CW-1:0]           idlen;
  logic [CW-1:0]           k;
  logic [CW-1:0]           need;
  logic                    clear;

  logic                    out_valid_q;
  status_e                 status_q;
  logic [IdWidth-1:0]      frame_id_q;
  logic                    extended_q;
  logic                    remote_q;
  logic [DlcWidth-1:0]     length_code_q;
  logic [PayloadWidth-1:0] payload_q;

  // the parser moves on whenever the output slot is free or being taken
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = item_valid_i && adv;

  assign idlen = ext_q ? CW'(8) : CW'(3);
  assign k     = count_q - (idlen + CW'(2));
  assign need  = idlen + CW'(2) + (rtr_q ? '0 : CW'({dlc_q, 1'b0}));

  always_comb begin
    count_d      = count_q;
    error_seen_d = error_seen_q;
    line_bad_d   = line_bad_q;
    ext_d        = ext_q;
    rtr_d        = rtr_q;
    id_d         = id_q;
    dlc_d        = dlc_q;
    data_d       = data_q;
    res_valid    = 1'b0;
    res_status   = STATUS_OK;
    res_id       = '0;
    res_ext      = 1'b0;
    res_rtr      = 1'b0;
    res_dlc      = '0;
    res_data     = '0;
    clear        = 1'b0;

    if (pop_o) begin
      case (item_i.kind)
        KIND_ERR: begin
          error_seen_d = 1'b1;
        end
        KIND_CHAR, KIND_TERM: begin
          if (count_q >= MaxCount) begin
            res_valid  = 1'b1;
            res_status = STATUS_TOO_LONG;
            clear      = 1'b1;
          end else if (item_i.kind == KIND_CHAR) begin
            count_d = count_q + 1'b1;
            if (!line_bad_q) begin
              if (count_q == '0) begin
                if (item_i.cmd_ok) begin
                  ext_d = item_i.cmd_ext;
                  rtr_d = item_i.cmd_rtr;
                end else begin
                  line_bad_d = 1'b1;
                end
              end else if (count_q <= idlen) begin
                if (item_i.hex_ok) begin
                  id_d = {id_q[IdWidth-5:0], item_i.nib};
                end else begin
                  line_bad_d = 1'b1;
                end
              end else if (count_q == idlen + CW'(1)) begin
                if (item_i.dlc_ok) begin
                  dlc_d = item_i.nib;
                end else begin
                  line_bad_d = 1'b1;
                end
              end else if (!rtr_q) begin
                if (k < CW'({dlc_q, 1'b0}) && k < CW'(NibbleCount)) begin
                  if (item_i.hex_ok) begin
                    for (int i = 0; i < NibbleCount; i++) begin
                      if (k[3:0] == 4'(i)) begin
                        data_d[PayloadWidth-1-4*i -: 4] =
                          data_q[PayloadWidth-1-4*i -: 4] | item_i.nib;
                      end
                    end
                  end else begin
                    line_bad_d = 1'b1;
                  end
                end
              end
            end
          end else begin
            // terminator
            res_valid = 1'b1;
            clear     = 1'b1;
            if (error_seen_q) begin
              error_seen_d = 1'b0;
              res_status   = STATUS_ABORTED;
            end else if (line_bad_q || count_q < need) begin
              res_status = STATUS_BAD;
            end else begin
              res_status = STATUS_OK;
              res_id     = ext_q ? id_q : {{(IdWidth-11){1'b0}}, id_q[10:0]};
              res_ext    = ext_q;
              res_rtr    = rtr_q;
              res_dlc    = dlc_q;
              res_data   = rtr_q ? '0 : data_q;
            end
          end
        end
        default: begin
          error_seen_d = error_seen_q;
        end
      endcase
    end

    if (clear) begin
      count_d    = '0;
      line_bad_d = 1'b0;
      ext_d      = 1'b0;
      rtr_d      = 1'b0;
      id_d       = '0;
      dlc_d      = '0;
      data_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      error_seen_q <= 1'b0;
      line_bad_q   <= 1'b0;
      ext_q        <= 1'b0;
      rtr_q        <= 1'b0;
      id_q         <= '0;
      dlc_q        <= '0;
      data_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      error_seen_q <= error_seen_d;
      line_bad_q   <= line_bad_d;
      ext_q        <= ext_d;
      rtr_q        <= rtr_d;
      id_q         <= id_d;
      dlc_q        <= dlc_d;
      data_q       <= data_d;
      if (adv) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      status_q      <= res_status;
      frame_id_q    <= res_id;
      extended_q    <= res_ext;
      remote_q      <= res_rtr;
      length_code_q <= res_dlc;
      payload_q     <= res_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign frame_id_o    = frame_id_q;
  assign extended_o    = extended_q;
  assign remote_o      = remote_q;
  assign length_code_o = length_code_q;
  assign payload_o     = payload_q;

endmodule

`default_nettype wire

>>> rtl/slcan_ascii_frame_decoder.sv
// an accepted terminating item passes the queue and the parser into the output register
// throughput: one item per cycle, set by the parser taking one queued item per cycle
// input stall rises only when the two-entry queue is full; output stall holds the parser
// reset: asynchronous active low, clears queue, line state, error flag and carrier mode
// no clearing pass after reset; items are taken from the first cycle
// depends on slcan_pkg, slcan_front, slcan_fifo, slcan_back
`default_nettype none

module slcan_ascii_frame_decoder import slcan_pkg::*; #(
  parameter int unsigned MAX_LINE = MaxLineDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration write channel, carrier mode only
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic                    cfg_data_i,
  // received items
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [7:0]              rx_byte_i,
  input  wire logic                    line_error_i,
  input  wire logic                    carrier_on_i,
  // decoded frames and line status
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [1:0]                   status_o,
  output logic [IdWidth-1:0]           frame_id_o,
  output logic                         extended_o,
  output logic                         remote_o,
  output logic [DlcWidth-1:0]          length_code_o,
  output logic [PayloadWidth-1:0]      payload_o
);

  item_t front_item;
  item_t queue_item;
  logic  queue_full;
  logic  queue_valid;
  logic  queue_pop;
  logic  in_accept;

  // the carrier mode register is always writable
  assign cfg_ready_o = 1'b1;

  // an item is taken whenever the queue has room, whatever the output side does
  assign in_stall_o = queue_full;
  assign in_accept  = in_valid_i && !queue_full;

  // classify the received item: error, terminator, or a character with its decodes
  slcan_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .rx_byte_i    (rx_byte_i),
    .line_error_i (line_error_i),
    .carrier_on_i (carrier_on_i),
    .item_o       (front_item)
  );

  // short queue so front and parser stall independently
  slcan_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  // line parser and output register
  slcan_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (queue_valid),
    .item_i        (queue_item),
    .pop_o         (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .frame_id_o    (frame_id_o),
    .extended_o    (extended_o),
    .remote_o      (remote_o),
    .length_code_o (length_code_o),
    .payload_o     (payload_o)
  );

endmodule

`default_nettype wire

>>> rtl/slcan_checker.sv
// port-level checks on the decoder outputs, bound to the top level
// depends on slcan_pkg and slcan_ascii_frame_decoder
`default_nettype none

module slcan_checker import slcan_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [1:0]              status_o,
  input wire logic [IdWidth-1:0]      frame_id_o,
  input wire logic                    extended_o,
  input wire logic                    remote_o,
  input wire logic [DlcWidth-1:0]     length_code_o,
  input wire logic [PayloadWidth-1:0] payload_o
);

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(frame_id_o)
      && $stable(payload_o) && $stable(length_code_o))
    else $error("result changed while stalled");

  // error results carry no frame contents
  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> frame_id_o == '0 && !extended_o
      && !remote_o && length_code_o == '0 && payload_o == '0)
    else $error("error result with frame contents");

  // a good frame is well formed
  a_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |-> length_code_o <= 4'd8
      && (extended_o || frame_id_o[IdWidth-1:11] == '0)
      && (!remote_o || payload_o == '0))
    else $error("malformed frame result");

endmodule

bind slcan_ascii_frame_decoder slcan_checker u_slcan_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .frame_id_o    (frame_id_o),
  .extended_o    (extended_o),
  .remote_o      (remote_o),
  .length_code_o (length_code_o),
  .payload_o     (payload_o)
);

`default_nettype wire

>>> tb/tb_slcan_ascii_frame_decoder.sv
// self-checking testbench for slcan_ascii_frame_decoder: directed lines, then random lines
// with faults and random idling on both channels, checked against an in-bench line decoder
// depends on slcan_pkg and the rtl of slcan_ascii_frame_decoder
`timescale 1ns / 100ps

module tb_slcan_ascii_frame_decoder;
  import slcan_pkg::*;

  // one decoded line as the block reports it
  typedef struct packed {
    status_e                 status;
    logic [IdWidth-1:0]      id;
    logic                    ext;
    logic                    rtr;
    logic [DlcWidth-1:0]     dlc;
    logic [PayloadWidth-1:0] data;
  } frame_t;

  // fault injected on the first character of a directed line
  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_PARITY,
    FAULT_CARRIER
  } fault_e;

  typedef struct {
    string      text;
    fault_e     fault;
    logic [7:0] term;
    bit         typed;   // want holds a hand-written result
    frame_t     want;
  } line_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    cfg_data_i = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              rx_byte_i = 8'h00;
  logic                    line_error_i = 1'b0;
  logic                    carrier_on_i = 1'b1;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              status_o;
  logic [IdWidth-1:0]      frame_id_o;
  logic                    extended_o;
  logic                    remote_o;
  logic [DlcWidth-1:0]     length_code_o;
  logic [PayloadWidth-1:0] payload_o;

  slcan_ascii_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .line_error_i  (line_error_i),
    .carrier_on_i  (carrier_on_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .frame_id_o    (frame_id_o),
    .extended_o    (extended_o),
    .remote_o      (remote_o),
    .length_code_o (length_code_o),
    .payload_o     (payload_o)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line decoder mirror: its own copy of the carrier mode and the line state
  // ---------------------------------------------------------------------------
  logic                    carrier_mode;    // 1: carrier loss is not a fault
  logic [5:0]              stored_chars;
  logic                    fault_pending;   // line or carrier fault since the last line
  logic                    parse_failed;
  logic                    ext_frame;
  logic                    rtr_frame;
  logic [31:0]             id_digits;
  logic [DlcWidth-1:0]     dlc_seen;
  logic [PayloadWidth-1:0] data_digits;

  frame_t    expected_frames[$];
  line_row_t directed_lines[$];
  int        mismatch_count = 0;
  int        chars_sent = 0;
  bit        sender_calm = 1'b0;

  function automatic void wipe_line();
    stored_chars = '0;
    parse_failed = 1'b0;
    ext_frame    = 1'b0;
    rtr_frame    = 1'b0;
    id_digits    = '0;
    dlc_seen     = '0;
    data_digits  = '0;
  endfunction

  // hex digit of either case; returns 0 for anything else
  function automatic bit hex_nibble(input logic [7:0] ch, output logic [3:0] nib);
    nib = 4'h0;
    if (ch >= "0" && ch <= "9") begin
      nib = ch[3:0];
      return 1'b1;
    end
    if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
      nib = ch[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one stored character of the line; once the line is bad the rest is skipped
  function automatic void parse_char(input logic [7:0] ch);
    int         pos;
    int         id_len;
    int         k;
    logic [3:0] nib;
    pos    = stored_chars;
    id_len = ext_frame ? 8 : 3;
    if (parse_failed) return;
    if (pos == 0) begin
      if (ch == "t" || ch == "r") begin
        ext_frame = 1'b0;
      end else if (ch == "T" || ch == "R") begin
        ext_frame = 1'b1;
      end else begin
        parse_failed = 1'b1;
        return;
      end
      rtr_frame = (ch == "r" || ch == "R");
    end else if (pos <= id_len) begin
      if (!hex_nibble(ch, nib)) parse_failed = 1'b1;
      else id_digits = {id_digits[27:0], nib};
    end else if (pos == id_len + 1) begin
      if (ch < "0" || ch > "8") parse_failed = 1'b1;
      else dlc_seen = ch[3:0];
    end else if (!rtr_frame) begin
      // data digits fill the payload from the top nibble down, extras are trailing
      k = pos - (id_len + 2);
      if (k < 2 * dlc_seen && k < 16) begin
        if (!hex_nibble(ch, nib)) parse_failed = 1'b1;
        else data_digits |= PayloadWidth'(nib) << (60 - 4 * k);
      end
    end
  endfunction

  // returns 1 when the character completes a result
  function automatic bit decode_char(input logic [7:0] ch, input logic lerr,
                                     input logic carrier, output frame_t res);
    int need;
    res = '0;
    if (lerr || (!carrier && !carrier_mode)) begin
      fault_pending = 1'b1;
      return 1'b0;
    end
    // full line: this character is lost whatever it is, the fault flag survives
    if (stored_chars >= MaxLineDefault) begin
      res.status = STATUS_TOO_LONG;
      wipe_line();
      return 1'b1;
    end
    if (ch != ChCr && ch != ChBel) begin
      parse_char(ch);
      stored_chars++;
      return 1'b0;
    end
    if (fault_pending) begin
      fault_pending = 1'b0;
      res.status = STATUS_ABORTED;
      wipe_line();
      return 1'b1;
    end
    need = (ext_frame ? 8 : 3) + 2 + (rtr_frame ? 0 : 2 * dlc_seen);
    if (parse_failed || stored_chars < need) begin
      res.status = STATUS_BAD;
    end else begin
      res.status = STATUS_OK;
      res.id     = ext_frame ? id_digits[28:0] : {18'b0, id_digits[10:0]};
      res.ext    = ext_frame;
      res.rtr    = rtr_frame;
      res.dlc    = dlc_seen;
      res.data   = rtr_frame ? '0 : data_digits;
    end
    wipe_line();
    return 1'b1;
  endfunction

  function automatic frame_t make_frame(input status_e st, input logic [IdWidth-1:0] id,
                                        input logic ext, input logic rtr,
                                        input logic [DlcWidth-1:0] dlc,
                                        input logic [PayloadWidth-1:0] data);
    frame_t f;
    f.status = st;
    f.id     = id;
    f.ext    = ext;
    f.rtr    = rtr;
    f.dlc    = dlc;
    f.data   = data;
    return f;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + nib;
    return ($urandom_range(0, 1) ? "A" : "a") + nib - 8'd10;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: inputs move at the falling edge, acceptance is seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] ch, input logic lerr, input logic carrier,
                           input bit typed, input frame_t want);
    int     gap;
    frame_t res;
    gap = sender_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    rx_byte_i    = ch;
    line_error_i = lerr;
    carrier_on_i = carrier;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_char(ch, lerr, carrier, res)) expected_frames.push_back(typed ? want : res);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_carrier_mode(input logic mode);
    cfg_valid_i = 1'b1;
    cfg_data_i  = mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    carrier_mode = mode;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wait for every result, then let lines with no result work through the pipe
  task automatic settle();
    in_valid_i = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic add_line(input string text, input fault_e fault, input logic [7:0] term,
                          input bit typed, input frame_t want);
    line_row_t row;
    row.text  = text;
    row.fault = fault;
    row.term  = term;
    row.typed = typed;
    row.want  = want;
    directed_lines.push_back(row);
  endtask

  // mostly well-formed frames with random content, the rest broken, overlong or noise
  task automatic send_random_line();
    logic [7:0] chars[$];
    int         style;
    int         fault_rate;
    int         dlc;
    bit         ext;
    bit         rtr;
    bit         all_ones;
    style      = $urandom_range(0, 99);
    fault_rate = (style >= 94) ? 15 : 1;
    if (style >= 78 && style < 94) begin
      // overlong printable lines around the limit, or short bursts of any byte
      repeat (style < 86 ? $urandom_range(30, 40) : $urandom_range(1, 6))
        chars.push_back(style < 86 ? 8'($urandom_range(8'h20, 8'h7e))
                                   : 8'($urandom_range(0, 255)));
    end else begin
      ext      = $urandom_range(0, 1);
      rtr      = $urandom_range(0, 1);
      all_ones = ($urandom_range(0, 7) == 0);
      chars.push_back(rtr ? (ext ? "R" : "r") : (ext ? "T" : "t"));
      repeat (ext ? 8 : 3) chars.push_back(hex_char(all_ones ? 4'hf : 4'($urandom_range(0, 15))));
      dlc = all_ones ? 8 : $urandom_range(0, 8);
      chars.push_back(8'("0" + dlc));
      if (!rtr)
        repeat (2 * dlc) chars.push_back(hex_char(all_ones ? 4'hf : 4'($urandom_range(0, 15))));
      // trailing characters after a complete frame
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(8'h20, 8'h7e)));
      if (style >= 55 && style < 70) begin
        chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (style >= 70 && style < 78) begin
        repeat ($urandom_range(1, chars.size())) void'(chars.pop_back());
      end
    end
    chars.push_back($urandom_range(0, 1) ? ChCr : ChBel);
    foreach (chars[i])
      send_item(chars[i], $urandom_range(0, 99) < fault_rate,
                !($urandom_range(0, 99) < fault_rate), 1'b0, '0);
    if ($urandom_range(0, 5) == 0) sender_calm = !sender_calm;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall per result, checked in order of arrival
  // ---------------------------------------------------------------------------
  task automatic check_frame(input frame_t got);
    frame_t want;
    if (expected_frames.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: status %0d id %h ext %b rtr %b dlc %0d data %h",
                 got.status, got.id, got.ext, got.rtr, got.dlc, got.data);
    end else begin
      want = expected_frames.pop_front();
      if (got.status !== want.status || got.id !== want.id || got.ext !== want.ext ||
          got.rtr !== want.rtr || got.dlc !== want.dlc || got.data !== want.data) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected status %0d id %h ext %b rtr %b dlc %0d data %h,",
                   want.status, want.id, want.ext, want.rtr, want.dlc, want.data,
                   " got status %0d id %h ext %b rtr %b dlc %0d data %h",
                   got.status, got.id, got.ext, got.rtr, got.dlc, got.data);
      end
    end
  endtask

  initial begin
    int     hold;
    bit     calm;
    frame_t got;
    calm = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.status = status_e'(status_o);
      got.id     = frame_id_o;
      got.ext    = extended_o;
      got.rtr    = remote_o;
      got.dlc    = length_code_o;
      got.data   = payload_o;
      check_frame(got);
      if ($urandom_range(0, 11) == 0) calm = !calm;
      @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin
    frame_t bad_line;
    frame_t aborted;
    int     phase_start;
    bad_line = make_frame(STATUS_BAD, '0, 1'b0, 1'b0, '0, '0);
    aborted  = make_frame(STATUS_ABORTED, '0, 1'b0, 1'b0, '0, '0);
    carrier_mode  = 1'b0;
    fault_pending = 1'b0;
    wipe_line();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed lines, carrier loss counts as a fault
    write_carrier_mode(1'b0);
    // empty line
    add_line("", FAULT_NONE, ChCr, 1'b1, bad_line);
    // standard remote frame, top id bit above 11 bits dropped
    add_line("rfFF0", FAULT_NONE, ChCr, 1'b1,
             make_frame(STATUS_OK, 29'h7ff, 1'b0, 1'b1, 4'd0, '0));
    // extended data frame, every field at its top value
    add_line("T1fffFFFF8ffffffffFFFFFFFF", FAULT_NONE, ChBel, 1'b1,
             make_frame(STATUS_OK, 29'h1fffffff, 1'b1, 1'b0, 4'd8, '1));
    // uart fault, then carrier loss: the next terminator aborts
    add_line("z", FAULT_PARITY, ChCr, 1'b1, aborted);
    add_line("z", FAULT_CARRIER, ChBel, 1'b1, aborted);
    // unknown command, non-hex id digit, dlc out of range, line short of its data
    add_line("x", FAULT_NONE, ChCr, 1'b1, bad_line);
    add_line("t12G", FAULT_NONE, ChCr, 1'b1, bad_line);
    add_line("t1239", FAULT_NONE, ChCr, 1'b1, bad_line);
    add_line("t1231A", FAULT_NONE, ChCr, 1'b1, bad_line);
    // trailing characters after a complete frame
    add_line("t5A31c4zz", FAULT_NONE, ChCr, 1'b0, '0);

    foreach (directed_lines[r]) begin
      for (int i = 0; i < directed_lines[r].text.len(); i++)
        send_item(directed_lines[r].text[i],
                  directed_lines[r].fault == FAULT_PARITY && i == 0,
                  !(directed_lines[r].fault == FAULT_CARRIER && i == 0), 1'b0, '0);
      send_item(directed_lines[r].term, 1'b0, 1'b1, directed_lines[r].typed,
                directed_lines[r].want);
    end
    settle();

    // random lines under alternating carrier modes
    for (int phase = 0; phase < 3; phase++) begin
      write_carrier_mode(phase != 1);
      phase_start = chars_sent;
      while (chars_sent - phase_start < 400) send_random_line();
      settle();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/slcan_pkg.sv
rtl/slcan_front.sv
rtl/slcan_fifo.sv
rtl/slcan_back.sv
rtl/slcan_ascii_frame_decoder.sv
rtl/slcan_checker.sv
tb/tb_slcan_ascii_frame_decoder.sv
